### rtl/swrm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stack with middle removal.
// No dependencies.
package swrm_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int WORD_W        = 32;

  localparam logic [1:0] OP_PUSH       = 2'd0;
  localparam logic [1:0] OP_POP        = 2'd1;
  localparam logic [1:0] OP_REMOVE_MID = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] pop_value;
    logic [7:0]               entry_count;
    logic                     is_empty;
  } rsp_t;

endpackage

### rtl/swrm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/swrm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the stack: entry count, RAM accesses, shift loop for middle removal.
// Depends on swrm_pkg; drives one swrm_ram instance through the top level.
module swrm_ctrl import swrm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  cmd_t                     cmd,
  input  logic                     res_free,
  output logic                     res_valid,
  output rsp_t                     res,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [WORD_W-1:0]        ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [WORD_W-1:0]        ram_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_POP   = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] wr_idx, wr_idx_next;
  logic          accept;
  logic          full;
  logic          empty;
  logic [CW-1:0] pos;

  function automatic rsp_t mk_res(logic [1:0] st, logic [WORD_W-1:0] val,
                                  logic [CW-1:0] cnt);
    rsp_t r;
    r.status      = st;
    r.pop_value   = val;
    r.entry_count = 8'(cnt);
    r.is_empty    = (cnt == '0);
    return r;
  endfunction

  assign cmd_ready = (state == S_IDLE) && res_free;
  assign accept    = cmd_valid && cmd_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pos       = count - CW'(1) - (count >> 1);

  always_comb begin
    state_next  = state;
    count_next  = count;
    wr_idx_next = wr_idx;
    res_valid   = 1'b0;
    res         = mk_res(ST_OK, '0, count);
    ram_we      = 1'b0;
    ram_waddr   = wr_idx;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = AW'(count - CW'(1));
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.opcode)
            OP_PUSH: begin
              res_valid = 1'b1;
              if (full) begin
                res = mk_res(ST_OVERFLOW, '0, count);
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(count);
                ram_wdata  = cmd.push_value;
                count_next = count + CW'(1);
                res        = mk_res(ST_OK, '0, count_next);
              end
            end
            OP_POP: begin
              if (empty) begin
                res_valid = 1'b1;
                res       = mk_res(ST_UNDERFLOW, '1, count);
              end else begin
                ram_re     = 1'b1;
                count_next = count - CW'(1);
                state_next = S_POP;
              end
            end
            OP_REMOVE_MID: begin
              if (empty) begin
                res_valid = 1'b1;
                res       = mk_res(ST_UNDERFLOW, '1, count);
              end else if (count == CW'(1)) begin
                res_valid  = 1'b1;
                count_next = '0;
                res        = mk_res(ST_OK, '0, count_next);
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = AW'(pos + CW'(1));
                wr_idx_next = AW'(pos);
                state_next  = S_SHIFT;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        res_valid  = 1'b1;
        res        = mk_res(ST_OK, ram_rdata, count);
        state_next = S_IDLE;
      end
      S_SHIFT: begin
        ram_we = 1'b1;
        if (CW'(wr_idx) + CW'(2) == count) begin
          count_next = count - CW'(1);
          res_valid  = 1'b1;
          res        = mk_res(ST_OK, '0, count_next);
          state_next = S_IDLE;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = wr_idx + AW'(2);
          wr_idx_next = wr_idx + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    wr_idx <= wr_idx_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_free)
    else $error("result produced while result register busy");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (CW'(wr_idx) + CW'(1) < count))
    else $error("shift index outside live entries");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == OP_PUSH && !full) |=> (count == $past(count) + CW'(1)))
    else $error("push did not advance count");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd_ready)
    else $error("command accepted while busy");

endmodule

### rtl/stack_with_remove_middle.sv
`timescale 1ns / 1ps
// Bounded LIFO stack of signed words with a remove-middle operation.
// Channels: cmd (opcode, push_value) in, rsp (status, pop_value, entry_count,
// is_empty) out, both valid/ready; one rsp transaction for every cmd transaction.
// Entries live in a single swrm_ram; swrm_ctrl sequences reads and writes.
// Per command: push, overflow, underflow and opcode 3 complete in the idle state;
// pop issues a RAM read and returns the word from the S_POP state; remove-middle
// walks the S_SHIFT state, one entry moved per cycle through the RAM
// read/write ports.
// The result sits in an output register; in idle, a new command is taken while
// that register is empty or being drained in the same cycle. When the receiver
// stalls, the result holds and cmd_ready stays low until it is taken.
// Reset (rst, synchronous) empties the stack and drops any pending result;
// RAM contents are not cleared and no clearing pass is needed.
// Depends on swrm_pkg, swrm_ctrl, swrm_ram.
module stack_with_remove_middle import swrm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);

  logic              res_free;
  logic              res_valid;
  rsp_t              res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign res_free = !rsp_valid || rsp_ready;

  swrm_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  swrm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (res_valid) begin
      rsp <= res;
    end
  end

endmodule
